FILE: rtl/auip_pkg.sv
`timescale 1ns / 1ps

package auip_pkg;

   localparam int BASE_WIDTH  = 6;
   localparam int VALUE_WIDTH = 128;
   localparam int RSP_COUNT_WIDTH = 16;
   localparam int DIGIT_WIDTH = 6;

   localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = 6'd36;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [7:0] CHAR_X_UPPER = 8'h58;
   localparam logic [7:0] CHAR_B_LOWER = 8'h62;
   localparam logic [7:0] CHAR_B_UPPER = 8'h42;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIPWS,
      PH_ZERO_AUTO,
      PH_ZERO_FIXED,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]     value;
      logic [RSP_COUNT_WIDTH-1:0] count;
      logic [BASE_WIDTH-1:0]      base;
   } rsp_word_type;

   function automatic logic [DIGIT_WIDTH-1:0] digit_value(input logic [7:0] c);
      logic [DIGIT_WIDTH-1:0] d;
      d = NO_DIGIT;
      if (c inside {[8'h30:8'h39]}) d = DIGIT_WIDTH'(c - 8'h30);
      else if (c inside {[8'h61:8'h7A]}) d = DIGIT_WIDTH'(c - 8'h61 + 8'd10);
      else if (c inside {[8'h41:8'h5A]}) d = DIGIT_WIDTH'(c - 8'h41 + 8'd10);
      return d;
   endfunction

endpackage

FILE: rtl/ascii_unsigned_integer_parser.sv
`timescale 1ns / 1ps

// channel   dir  handshake          word
// req_      in   valid / stall      char_byte, first_of_string
// rsp_      out  valid / stall      value_low, value_high, consumed_count, base_used
// csr_      in   valid / ready      base (ready always high)
//
// One character is taken every cycle while req_stall is low; the 128-bit multiply-accumulate by the
// base and the phase update sit between the request port and the state registers.
// A result is registered into a two-word queue when its terminating character is taken.
// req_stall rises only while both queue words wait on rsp_stall.
// Synchronous reset clears phase, base register and the queue; no clearing pass.

module ascii_unsigned_integer_parser #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_char_byte,
   input  logic                                   req_first_of_string,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [63:0]                            rsp_value_low,
   output logic [63:0]                            rsp_value_high,
   output logic [auip_pkg::RSP_COUNT_WIDTH-1:0]   rsp_consumed_count,
   output logic [auip_pkg::BASE_WIDTH-1:0]        rsp_base_used,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [auip_pkg::BASE_WIDTH-1:0]        csr_base
);
   import auip_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [BASE_WIDTH-1:0]  base_ff;
   phase_type              phase_ff, phase_in, phase_start;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, acc_start, acc_prod;
   logic [BASE_WIDTH-1:0]  eb_ff, eb_in, eb_start, eb_mid;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_start;

   logic                   req_fire, rsp_pop, push;
   logic                   is_space, is_zero, is_x, is_b, prefix_match, digit_ok;
   logic [DIGIT_WIDTH-1:0] digit;
   logic                   count_inc, take_digit, emit;

   logic [1:0]             occ_ff, occ_in;
   rsp_word_type           head_ff, head_in, spare_ff, spare_in, new_word;
   logic [COUNT_WIDTH+RSP_COUNT_WIDTH-1:0] cnt_wide;

   assign csr_ready = 1'b1;
   assign req_stall = (occ_ff == 2'd2);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_pop   = rsp_valid && !rsp_stall;

   // a first_of_string character restarts from a clean state
   assign phase_start = req_first_of_string ? PH_SKIPWS : phase_ff;
   assign acc_start   = req_first_of_string ? '0 : acc_ff;
   assign cnt_start   = req_first_of_string ? '0 : cnt_ff;
   assign eb_start    = req_first_of_string ? base_ff : eb_ff;

   assign is_space = (req_char_byte == CHAR_SPACE) ||
                     (req_char_byte inside {[CHAR_TAB:CHAR_CR]});
   assign is_zero  = (req_char_byte == CHAR_ZERO);
   assign is_x     = (req_char_byte == CHAR_X_LOWER) || (req_char_byte == CHAR_X_UPPER);
   assign is_b     = (req_char_byte == CHAR_B_LOWER) || (req_char_byte == CHAR_B_UPPER);
   assign prefix_match = (eb_start == BASE_HEX && is_x) || (eb_start == BASE_BIN && is_b);
   assign digit    = digit_value(req_char_byte);

   // base in force for this character after prefix detection
   always_comb begin
      eb_mid = eb_start;
      case (phase_start)
         PH_SKIPWS: begin
            if (eb_start == BASE_AUTO && !is_space && !is_zero) eb_mid = BASE_DEC;
         end
         PH_ZERO_AUTO: begin
            if (is_x) eb_mid = BASE_HEX;
            else if (is_b) eb_mid = BASE_BIN;
            else eb_mid = BASE_OCT;
         end
         default: eb_mid = eb_start;
      endcase
   end

   assign digit_ok = (digit != NO_DIGIT) && (digit < eb_mid);

   // next phase
   always_comb begin
      phase_in = phase_start;
      case (phase_start)
         PH_SKIPWS: begin
            if (is_space) phase_in = PH_SKIPWS;
            else if (eb_start == BASE_AUTO && is_zero) phase_in = PH_ZERO_AUTO;
            else if (eb_start != BASE_AUTO && is_zero &&
                     (eb_start == BASE_BIN || eb_start == BASE_HEX))
               phase_in = PH_ZERO_FIXED;
            else phase_in = digit_ok ? PH_DIGITS : PH_DONE;
         end
         PH_ZERO_AUTO: begin
            if (is_x || is_b) phase_in = PH_DIGITS;
            else phase_in = digit_ok ? PH_DIGITS : PH_DONE;
         end
         PH_ZERO_FIXED: begin
            if (prefix_match) phase_in = PH_DIGITS;
            else phase_in = digit_ok ? PH_DIGITS : PH_DONE;
         end
         PH_DIGITS: phase_in = digit_ok ? PH_DIGITS : PH_DONE;
         default:   phase_in = phase_start;
      endcase
   end

   // datapath controls
   always_comb begin
      count_inc  = 1'b0;
      take_digit = 1'b0;
      emit       = 1'b0;
      case (phase_start)
         PH_SKIPWS: begin
            if (is_space || (is_zero && (eb_start == BASE_AUTO ||
                eb_start == BASE_BIN || eb_start == BASE_HEX))) begin
               count_inc = 1'b1;
            end else begin
               take_digit = digit_ok;
               count_inc  = digit_ok;
               emit       = !digit_ok;
            end
         end
         PH_ZERO_AUTO: begin
            if (is_x || is_b) begin
               count_inc = 1'b1;
            end else begin
               take_digit = digit_ok;
               count_inc  = digit_ok;
               emit       = !digit_ok;
            end
         end
         PH_ZERO_FIXED: begin
            if (prefix_match) begin
               count_inc = 1'b1;
            end else begin
               take_digit = digit_ok;
               count_inc  = digit_ok;
               emit       = !digit_ok;
            end
         end
         PH_DIGITS: begin
            take_digit = digit_ok;
            count_inc  = digit_ok;
            emit       = !digit_ok;
         end
         default: begin
            count_inc  = 1'b0;
            take_digit = 1'b0;
            emit       = 1'b0;
         end
      endcase
   end

   // 128 x 6 multiply, wraps mod 2^128
   assign acc_prod = VALUE_WIDTH'(acc_start * VALUE_WIDTH'(eb_mid));
   assign acc_in   = take_digit ? acc_prod + VALUE_WIDTH'(digit) : acc_start;
   assign cnt_in   = (count_inc && cnt_start != COUNT_MAX) ? cnt_start + 1'b1 : cnt_start;
   assign eb_in    = eb_mid;

   assign cnt_wide       = {{RSP_COUNT_WIDTH{1'b0}}, cnt_start};
   assign new_word.value = acc_start;
   assign new_word.count = cnt_wide[RSP_COUNT_WIDTH-1:0];
   assign new_word.base  = eb_mid;
   assign push           = req_fire && emit;

   // two-word result queue: head drives the port, spare catches a word behind it
   always_comb begin
      occ_in   = occ_ff;
      head_in  = head_ff;
      spare_in = spare_ff;
      case (occ_ff)
         2'd0: begin
            if (push) begin
               head_in = new_word;
               occ_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && rsp_pop) begin
               head_in = new_word;
            end else if (push) begin
               spare_in = new_word;
               occ_in   = 2'd2;
            end else if (rsp_pop) begin
               occ_in = 2'd0;
            end
         end
         2'd2: begin
            if (rsp_pop) begin
               head_in = spare_ff;
               occ_in  = 2'd1;
            end
         end
         default: occ_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_AUTO;
         phase_ff <= PH_IDLE;
         occ_ff   <= 2'd0;
         acc_ff   <= '0;
         eb_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) base_ff <= csr_base;
         if (req_fire) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            eb_ff    <= eb_in;
            cnt_ff   <= cnt_in;
         end
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign rsp_value_low      = head_ff.value[63:0];
   assign rsp_value_high     = head_ff.value[127:64];
   assign rsp_consumed_count = head_ff.count;
   assign rsp_base_used      = head_ff.base;

endmodule

FILE: rtl/auip_checker.sv
`timescale 1ns / 1ps

module auip_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [63:0]                          rsp_value_low,
   input logic [63:0]                          rsp_value_high,
   input logic [auip_pkg::RSP_COUNT_WIDTH-1:0] rsp_consumed_count,
   input logic [auip_pkg::BASE_WIDTH-1:0]      rsp_base_used
);
   import auip_pkg::*;

   // a waiting result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_low) &&
      $stable(rsp_value_high) && $stable(rsp_consumed_count) && $stable(rsp_base_used))
      else $error("result word changed while stalled");

   // base detection always resolves to a real base
   a_base_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_base_used != BASE_AUTO)
      else $error("result with base zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a new result needs a character accepted the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without an accepted character");

endmodule

bind ascii_unsigned_integer_parser auip_checker u_auip_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_value_low      (rsp_value_low),
   .rsp_value_high     (rsp_value_high),
   .rsp_consumed_count (rsp_consumed_count),
   .rsp_base_used      (rsp_base_used)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import auip_pkg::*;

   localparam int LIMIT        = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_char_byte = 8'h00;
   logic                       req_first_of_string = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [63:0]                rsp_value_low;
   logic [63:0]                rsp_value_high;
   logic [RSP_COUNT_WIDTH-1:0] rsp_consumed_count;
   logic [BASE_WIDTH-1:0]      rsp_base_used;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [BASE_WIDTH-1:0]      csr_base = '0;

   logic [7:0] blanks [6] = '{CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR};
   string      prefixes [5] = '{"0x", "0X", "0b", "0B", "0"};

   // parser mirror
   logic [BASE_WIDTH-1:0]      base_reg = BASE_AUTO;
   phase_type                  phase = PH_IDLE;
   logic [VALUE_WIDTH-1:0]     acc = '0;
   logic [BASE_WIDTH-1:0]      eff_base = '0;
   logic [RSP_COUNT_WIDTH-1:0] nchars = '0;
   rsp_word_type               expected_numbers [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int chars_sent    = 0;
   int mismatches    = 0;
   int cycles        = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;

   ascii_unsigned_integer_parser i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_byte       (req_char_byte),
      .req_first_of_string (req_first_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_low       (rsp_value_low),
      .rsp_value_high      (rsp_value_high),
      .rsp_consumed_count  (rsp_consumed_count),
      .rsp_base_used       (rsp_base_used),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_base            (csr_base)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void count_char();
      if (nchars != '1) nchars++;
   endfunction

   // Digit or terminator; the terminator closes the number.
   function automatic void take_digit(input logic [7:0] c);
      logic [BASE_WIDTH-1:0] d;
      rsp_word_type          w;
      d = NO_DIGIT;
      if (c >= "0" && c <= "9") d = BASE_WIDTH'(c - "0");
      else if (c >= "a" && c <= "z") d = BASE_WIDTH'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "Z") d = BASE_WIDTH'(c - "A" + 8'd10);
      phase = PH_DIGITS;
      if (d == NO_DIGIT || d >= eff_base) begin
         w.value = acc;
         w.count = nchars;
         w.base  = eff_base;
         expected_numbers.push_back(w);
         phase = PH_DONE;
      end else begin
         acc = acc * VALUE_WIDTH'(eff_base) + VALUE_WIDTH'(d);
         count_char();
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c, input logic starts);
      if (starts) begin
         phase    = PH_SKIPWS;
         acc      = '0;
         nchars   = '0;
         eff_base = base_reg;
      end
      case (phase)
         PH_SKIPWS: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
               count_char();
            end else if (eff_base == BASE_AUTO) begin
               if (c == CHAR_ZERO) begin
                  count_char();
                  phase = PH_ZERO_AUTO;
               end else begin
                  eff_base = BASE_DEC;
                  take_digit(c);
               end
            end else if (c == CHAR_ZERO && (eff_base == BASE_BIN || eff_base == BASE_HEX)) begin
               count_char();
               phase = PH_ZERO_FIXED;
            end else begin
               take_digit(c);
            end
         end
         PH_ZERO_AUTO: begin
            if (c == CHAR_X_LOWER || c == CHAR_X_UPPER) begin
               eff_base = BASE_HEX;
               count_char();
               phase = PH_DIGITS;
            end else if (c == CHAR_B_LOWER || c == CHAR_B_UPPER) begin
               eff_base = BASE_BIN;
               count_char();
               phase = PH_DIGITS;
            end else begin
               eff_base = BASE_OCT;
               take_digit(c);
            end
         end
         PH_ZERO_FIXED: begin
            if ((eff_base == BASE_HEX && (c == CHAR_X_LOWER || c == CHAR_X_UPPER)) ||
                (eff_base == BASE_BIN && (c == CHAR_B_LOWER || c == CHAR_B_UPPER))) begin
               count_char();
               phase = PH_DIGITS;
            end else begin
               take_digit(c);
            end
         end
         PH_DIGITS: take_digit(c);
         default: ;
      endcase
   endfunction

   // valid stays high from one character to the next unless the sender idles
   task automatic send_char(input logic [7:0] c, input logic starts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_char_byte       <= c;
      req_first_of_string <= starts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(c, starts);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input logic starts);
      for (int i = 0; i < s.len(); i++) send_char(s[i], starts && i == 0);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_WIDTH-1:0] b);
      csr_valid <= 1'b1;
      csr_base  <= b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      base_reg = b;
   endtask

   task automatic send_random_string();
      logic                  starts;
      logic [BASE_WIDTH-1:0] digit_base;
      logic [7:0]            t;
      int                    kind;
      int                    ndig;
      int                    v;
      starts = 1'b1;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_char(blanks[$urandom_range(5)], starts);
            starts = 1'b0;
         end
      end
      kind = $urandom_range(7);
      if (kind < 5) begin
         send_text(prefixes[kind], starts);
         starts = 1'b0;
      end
      if (base_reg != BASE_AUTO) digit_base = (base_reg > 6'd36) ? 6'd36 : base_reg;
      else if (kind < 2) digit_base = BASE_HEX;
      else if (kind < 4) digit_base = BASE_BIN;
      else if (kind == 4) digit_base = BASE_OCT;
      else digit_base = BASE_DEC;
      // now and then long enough to wrap the 128-bit value
      ndig = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(6);
      repeat (ndig) begin
         v = $urandom_range(digit_base - 1);
         if (v < 10) t = 8'(8'h30 + v);
         else t = 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
         send_char(t, starts);
         starts = 1'b0;
      end
      // a string left open is cut short by the next start
      if ($urandom_range(9) != 0) begin
         case ($urandom_range(3))
            0: t = 8'h00;
            1: t = blanks[$urandom_range(5)];
            2: t = ".";
            default: t = 8'($urandom_range(255));
         endcase
         send_char(t, starts);
      end
      repeat ($urandom_range(2)) send_char(8'($urandom_range(255)), 1'b0);
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_done != hold_requests) begin
         holds_done <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_words
      rsp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            mismatches++;
            if (mismatches <= 20)
               $display("%0t: unexpected word value %h%h count %0d base %0d", $time,
                        rsp_value_high, rsp_value_low, rsp_consumed_count, rsp_base_used);
         end else begin
            w = expected_numbers.pop_front();
            if (rsp_value_low !== w.value[63:0] || rsp_value_high !== w.value[127:64] ||
                rsp_consumed_count !== w.count || rsp_base_used !== w.base) begin
               mismatches++;
               if (mismatches <= 20)
                  $display({"%0t: expected value %h count %0d base %0d, ",
                            "actual value %h%h count %0d base %0d"},
                           $time, w.value, w.count, w.base, rsp_value_high, rsp_value_low,
                           rsp_consumed_count, rsp_base_used);
            end
         end
      end
   end

   task automatic test_directed();
      send_char(CHAR_SPACE, 1'b1);
      for (int i = 1; i < 6; i++) send_char(blanks[i], 1'b0);
      send_text("0xfF", 1'b0);
      send_char(8'h00, 1'b0);
      send_text("0b2", 1'b1);      // prefix with nothing after it
      send_text("078", 1'b1);
      send_char(8'hFF, 1'b1);      // terminator right at the start
      send_char("a", 1'b0);        // outside any string
      wait_idle();
      write_base(6'd1);
      send_text("01", 1'b1);
      wait_idle();
      write_base(6'd63);
      send_text("Zz.", 1'b1);
      wait_idle();
      write_base(BASE_HEX);
      send_text("0Xa ", 1'b1);
      wait_idle();
   endtask

   // count runs well past eight bits of leading blanks
   task automatic test_long_count();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_base(BASE_DEC);
      send_char(CHAR_SPACE, 1'b1);
      repeat (300) send_char(CHAR_SPACE, 1'b0);
      send_text("5", 1'b0);
      send_char(8'h00, 1'b0);
      wait_idle();
   endtask

   task automatic test_random();
      logic [BASE_WIDTH-1:0] bases [8] = '{BASE_AUTO, BASE_HEX, BASE_BIN, BASE_DEC,
                                           6'd36, 6'd63, 6'd1, BASE_AUTO};
      int goal;
      for (int i = 0; i < 8; i++) begin
         write_base(bases[i]);
         case (i % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         goal = chars_sent + 180;
         while (chars_sent < goal) begin
            if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            else send_random_string();
         end
         wait_idle();
      end
   endtask

   // receiver holds off while the sender keeps going until the block backs up
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_base(BASE_AUTO);
      hold_requests <= hold_requests + 1;
      repeat (40) send_random_string();
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_count();
      test_random();
      test_backpressure();
      wait_idle();
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
